// File: src/pbtie_pkg.sv
// Types and codes shared by the tensor initialiser extractor.
`timescale 1ns / 1ps
package pbtie_pkg;

   typedef enum logic [7:0] {
      PH_TAG    = 8'b0000_0001,
      PH_LEN    = 8'b0000_0010,
      PH_SKIPV  = 8'b0000_0100,
      PH_SKIPN  = 8'b0000_1000,
      PH_DIM    = 8'b0001_0000,
      PH_DTYPE  = 8'b0010_0000,
      PH_PACKED = 8'b0100_0000,
      PH_BYTES  = 8'b1000_0000
   } phase_type;

   typedef enum logic [3:0] {
      CL_SKIP   = 4'd0,
      CL_GRAPH  = 4'd1,
      CL_TENSOR = 4'd2,
      CL_DIMS   = 4'd3,
      CL_NAME   = 4'd4,
      CL_RAW    = 4'd5,
      CL_FLOAT  = 4'd6,
      CL_INT32  = 4'd7,
      CL_INT64  = 4'd8
   } class_type;

   typedef enum logic [1:0] {
      LVL_MODEL  = 2'd0,
      LVL_GRAPH  = 2'd1,
      LVL_TENSOR = 2'd2
   } level_type;

   typedef enum logic [3:0] {
      EV_START = 4'd0,
      EV_DIM   = 4'd1,
      EV_DTYPE = 4'd2,
      EV_NAME  = 4'd3,
      EV_RAW   = 4'd4,
      EV_FLOAT = 4'd5,
      EV_INT32 = 4'd6,
      EV_INT64 = 4'd7,
      EV_END   = 4'd8
   } event_type;

   localparam int unsigned SEEN_NAME  = 0;
   localparam int unsigned SEEN_RAW   = 1;
   localparam int unsigned SEEN_FLOAT = 2;
   localparam int unsigned SEEN_INT32 = 3;
   localparam int unsigned SEEN_INT64 = 4;

   localparam logic [2:0] SRC_NONE  = 3'd0;
   localparam logic [2:0] SRC_RAW   = 3'd1;
   localparam logic [2:0] SRC_FLOAT = 3'd2;
   localparam logic [2:0] SRC_INT32 = 3'd3;
   localparam logic [2:0] SRC_INT64 = 3'd4;

   localparam logic [3:0] WIRE_VARINT = 4'd0;

   typedef struct packed {
      event_type   kind;
      logic [63:0] value;
      logic [2:0]  source;
      logic        kept;
      logic        malformed;
      logic        last;
   } result_type;

endpackage

// File: src/protobuf_tensor_initializer_extractor.sv
// Top level: byte-serial protobuf parser that extracts tensor initialiser events.
//
// Usage: the model file enters on the req_ stream one byte per transfer, with
// req_tlast on its last byte. Each byte causes zero to three events on the rsp_
// stream; rsp_tlast marks the last event caused by a byte. Event kind is in
// rsp_tuser, value, data source, kept and malformed flags in rsp_tdata.
// The events of a byte are registered: they enter the results queue on accept.
// Throughput: one byte per cycle while the results queue holds at most one
// event; the four-entry results queue drains one event per cycle while
// rsp_tready is high, so a byte that causes two or three events holds input back.
// The parse state (length counters, varint accumulator, phase) updates in the
// same cycle a byte is accepted; the results are written into the queue.
// Reset empties the queue and returns the parser to the model level.
// When the receiver stalls, the queue fills and req_tready drops once more
// than one event is waiting; nothing is lost.
`timescale 1ns / 1ps
module protobuf_tensor_initializer_extractor #(
   parameter int unsigned LENGTH_BITS      = 32,
   parameter int unsigned MAX_VARINT_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] in_byte
   input  logic        req_tlast,  // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // [63:0] event_value, [66:64] data_source,
                                   // [67] tensor_kept, [68] malformed, rest zero
   output logic [3:0]  rsp_tuser,  // [3:0] event_kind
   output logic        rsp_tlast   // last_of_run
);

   localparam int unsigned LB = LENGTH_BITS;

   logic [LB-1:0]          graph_ff, graph_in, tensor_ff, tensor_in, field_ff, field_in;
   logic [63:0]            acc_ff, acc_in;
   logic [3:0]             cnt_ff, cnt_in;
   pbtie_pkg::phase_type   phase_ff, phase_in;
   pbtie_pkg::level_type   level_ff, level_in;
   pbtie_pkg::class_type   class_ff, class_in;
   logic [2:0]             wire_ff, wire_in;
   logic [4:0]             seen_ff, seen_in;
   logic                   fault_ff, fault_in;

   pbtie_pkg::result_type  fifo_ff [4];
   logic [1:0]             head_ff, head_in;
   logic [2:0]             count_ff, count_in;

   pbtie_pkg::result_type  res [3];
   logic [1:0]             n_res;
   logic                   accept, pop;

   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = count_ff <= 3'd1;
   assign rsp_tvalid = count_ff != 3'd0;
   assign rsp_tuser  = fifo_ff[head_ff].kind;
   assign rsp_tlast  = fifo_ff[head_ff].last;
   assign rsp_tdata  = {3'b000, fifo_ff[head_ff].malformed, fifo_ff[head_ff].kept,
                        fifo_ff[head_ff].source, fifo_ff[head_ff].value};

   function automatic logic [LB-1:0] clamp_len(input logic [LB-1:0] n,
                                               input pbtie_pkg::level_type lvl,
                                               input logic [LB-1:0] t,
                                               input logic [LB-1:0] g,
                                               inout logic flt);
      logic [LB-1:0] r;
      r = n;
      if (lvl == pbtie_pkg::LVL_TENSOR) begin
         if (n > t) begin
            r = t;
            flt = 1'b1;
         end
      end else if (lvl == pbtie_pkg::LVL_GRAPH) begin
         if (n > g) begin
            r = g;
            flt = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [2:0] pick_source(input logic [4:0] s);
      logic [2:0] r;
      r = pbtie_pkg::SRC_NONE;
      if (s[pbtie_pkg::SEEN_RAW])        r = pbtie_pkg::SRC_RAW;
      else if (s[pbtie_pkg::SEEN_FLOAT]) r = pbtie_pkg::SRC_FLOAT;
      else if (s[pbtie_pkg::SEEN_INT32]) r = pbtie_pkg::SRC_INT32;
      else if (s[pbtie_pkg::SEEN_INT64]) r = pbtie_pkg::SRC_INT64;
      return r;
   endfunction

   function automatic logic [63:0] sext32(input logic [63:0] v);
      return {{32{v[31]}}, v[31:0]};
   endfunction

   always_comb begin
      logic [7:0]    b;
      logic          body, done, incomplete;
      logic [63:0]   v, f;
      logic [LB-1:0] len;
      logic [3:0]    c;
      logic [2:0]    src;
      pbtie_pkg::phase_type ph;
      pbtie_pkg::event_type k;
      b          = req_tdata;
      graph_in   = graph_ff;
      tensor_in  = tensor_ff;
      field_in   = field_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      phase_in   = phase_ff;
      level_in   = level_ff;
      class_in   = class_ff;
      wire_in    = wire_ff;
      seen_in    = seen_ff;
      fault_in   = fault_ff;
      n_res      = 2'd0;
      done       = 1'b0;
      v          = '0;
      f          = '0;
      len        = '0;
      c          = '0;
      src        = '0;
      ph         = phase_ff;
      k          = pbtie_pkg::EV_FLOAT;
      incomplete = 1'b0;
      for (int i = 0; i < 3; i++) res[i] = '0;

      body = phase_ff == pbtie_pkg::PH_SKIPN || phase_ff == pbtie_pkg::PH_BYTES ||
             phase_ff == pbtie_pkg::PH_PACKED;
      if (level_ff != pbtie_pkg::LVL_MODEL && graph_in != '0) graph_in = graph_in - 1'b1;
      if (level_ff == pbtie_pkg::LVL_TENSOR && tensor_in != '0)
         tensor_in = tensor_in - 1'b1;
      if (body && field_in != '0) field_in = field_in - 1'b1;

      // varint byte intake, shared by the packed and scalar phases
      c = cnt_ff;
      if (c < 4'd10) acc_in = acc_ff | ({57'd0, b[6:0]} << (7 * c));
      c = c + 4'd1;
      done = !b[7] || (32'(c) >= MAX_VARINT_BYTES);

      case (phase_ff)
         pbtie_pkg::PH_SKIPN: begin
            acc_in = acc_ff;
         end
         pbtie_pkg::PH_BYTES: begin
            acc_in = acc_ff;
            k = class_ff == pbtie_pkg::CL_NAME ? pbtie_pkg::EV_NAME :
                class_ff == pbtie_pkg::CL_RAW  ? pbtie_pkg::EV_RAW : pbtie_pkg::EV_FLOAT;
            res[n_res] = '{k, {56'd0, b}, 3'd0, 1'b0, fault_in, 1'b0};
            n_res = n_res + 2'd1;
         end
         pbtie_pkg::PH_PACKED: begin
            cnt_in = c;
            if (done) begin
               v = acc_in;
               acc_in = '0;
               cnt_in = '0;
               if (class_ff == pbtie_pkg::CL_DIMS)
                  res[n_res] = '{pbtie_pkg::EV_DIM, v, 3'd0, 1'b0, fault_in, 1'b0};
               else if (class_ff == pbtie_pkg::CL_INT32)
                  res[n_res] = '{pbtie_pkg::EV_INT32, sext32(v), 3'd0, 1'b0, fault_in, 1'b0};
               else
                  res[n_res] = '{pbtie_pkg::EV_INT64, v, 3'd0, 1'b0, fault_in, 1'b0};
               n_res = n_res + 2'd1;
            end
         end
         default: begin
            cnt_in = c;
            if (done) begin
               v = acc_in;
               acc_in = '0;
               cnt_in = '0;
               phase_in = pbtie_pkg::PH_TAG;
               if (ph == pbtie_pkg::PH_TAG) begin
                  f = v >> 3;
                  wire_in = v[2:0];
                  if ((level_ff == pbtie_pkg::LVL_MODEL && f == 64'd7 && v[2:0] == 3'd2) ||
                      (level_ff == pbtie_pkg::LVL_GRAPH && f == 64'd5 && v[2:0] == 3'd2)) begin
                     class_in = level_ff == pbtie_pkg::LVL_MODEL ? pbtie_pkg::CL_GRAPH :
                                pbtie_pkg::CL_TENSOR;
                     phase_in = pbtie_pkg::PH_LEN;
                  end else if (level_ff == pbtie_pkg::LVL_TENSOR && f == 64'd1) begin
                     if (v[2:0] == 3'd2) begin
                        class_in = pbtie_pkg::CL_DIMS;
                        phase_in = pbtie_pkg::PH_LEN;
                     end else phase_in = pbtie_pkg::PH_DIM;
                  end else if (level_ff == pbtie_pkg::LVL_TENSOR && f == 64'd2) begin
                     phase_in = pbtie_pkg::PH_DTYPE;
                  end else if (level_ff == pbtie_pkg::LVL_TENSOR && v[2:0] == 3'd2 &&
                               (f == 64'd4 || f == 64'd5 || f == 64'd7)) begin
                     class_in = f == 64'd4 ? pbtie_pkg::CL_FLOAT :
                                f == 64'd5 ? pbtie_pkg::CL_INT32 : pbtie_pkg::CL_INT64;
                     phase_in = pbtie_pkg::PH_LEN;
                  end else if (level_ff == pbtie_pkg::LVL_TENSOR && f == 64'd8) begin
                     class_in = pbtie_pkg::CL_NAME;
                     phase_in = pbtie_pkg::PH_LEN;
                  end else if (level_ff == pbtie_pkg::LVL_TENSOR && f == 64'd13) begin
                     class_in = pbtie_pkg::CL_RAW;
                     phase_in = pbtie_pkg::PH_LEN;
                  end else begin
                     // skip by wire type
                     class_in = pbtie_pkg::CL_SKIP;
                     if ({1'b0, v[2:0]} == pbtie_pkg::WIRE_VARINT)
                        phase_in = pbtie_pkg::PH_SKIPV;
                     else if (v[2:0] == 3'd1) begin
                        field_in = clamp_len(LB'(8), level_ff, tensor_in, graph_in, fault_in);
                        phase_in = pbtie_pkg::PH_SKIPN;
                     end else if (v[2:0] == 3'd5) begin
                        field_in = clamp_len(LB'(4), level_ff, tensor_in, graph_in, fault_in);
                        phase_in = pbtie_pkg::PH_SKIPN;
                     end else if (v[2:0] == 3'd2) phase_in = pbtie_pkg::PH_LEN;
                  end
               end else if (ph == pbtie_pkg::PH_LEN) begin
                  if (v[63:LB] != '0) begin
                     len = '1;
                     fault_in = 1'b1;
                  end else len = v[LB-1:0];
                  case (class_ff)
                     pbtie_pkg::CL_GRAPH: begin
                        graph_in = len;
                        level_in = pbtie_pkg::LVL_GRAPH;
                     end
                     pbtie_pkg::CL_TENSOR: begin
                        tensor_in = clamp_len(len, level_ff, tensor_in, graph_in, fault_in);
                        level_in = pbtie_pkg::LVL_TENSOR;
                        seen_in = '0;
                        res[n_res] = '{pbtie_pkg::EV_START, 64'd0, 3'd0, 1'b0, fault_in, 1'b0};
                        n_res = n_res + 2'd1;
                     end
                     pbtie_pkg::CL_SKIP: begin
                        field_in = clamp_len(len, level_ff, tensor_in, graph_in, fault_in);
                        phase_in = pbtie_pkg::PH_SKIPN;
                     end
                     default: begin
                        field_in = clamp_len(len, level_ff, tensor_in, graph_in, fault_in);
                        if (class_ff == pbtie_pkg::CL_DIMS || class_ff == pbtie_pkg::CL_INT32 ||
                            class_ff == pbtie_pkg::CL_INT64)
                           phase_in = pbtie_pkg::PH_PACKED;
                        else phase_in = pbtie_pkg::PH_BYTES;
                        if (class_ff == pbtie_pkg::CL_NAME) seen_in[pbtie_pkg::SEEN_NAME] = 1'b1;
                        if (field_in != '0) begin
                           if (class_ff == pbtie_pkg::CL_RAW)
                              seen_in[pbtie_pkg::SEEN_RAW] = 1'b1;
                           else if (class_ff == pbtie_pkg::CL_FLOAT)
                              seen_in[pbtie_pkg::SEEN_FLOAT] = 1'b1;
                           else if (class_ff == pbtie_pkg::CL_INT32)
                              seen_in[pbtie_pkg::SEEN_INT32] = 1'b1;
                           else if (class_ff == pbtie_pkg::CL_INT64)
                              seen_in[pbtie_pkg::SEEN_INT64] = 1'b1;
                        end
                     end
                  endcase
               end else if (ph == pbtie_pkg::PH_DIM) begin
                  res[n_res] = '{pbtie_pkg::EV_DIM, v, 3'd0, 1'b0, fault_in, 1'b0};
                  n_res = n_res + 2'd1;
               end else if (ph == pbtie_pkg::PH_DTYPE) begin
                  res[n_res] = '{pbtie_pkg::EV_DTYPE, sext32(v), 3'd0, 1'b0, fault_in, 1'b0};
                  n_res = n_res + 2'd1;
               end
            end
         end
      endcase

      // close finished regions, innermost first
      body = phase_in == pbtie_pkg::PH_SKIPN || phase_in == pbtie_pkg::PH_BYTES ||
             phase_in == pbtie_pkg::PH_PACKED;
      if (body && field_in == '0) begin
         if (cnt_in != '0) fault_in = 1'b1;
         acc_in = '0;
         cnt_in = '0;
         phase_in = pbtie_pkg::PH_TAG;
      end
      if (level_in == pbtie_pkg::LVL_TENSOR && tensor_in == '0) begin
         if (phase_in != pbtie_pkg::PH_TAG || cnt_in != '0) fault_in = 1'b1;
         acc_in = '0;
         cnt_in = '0;
         phase_in = pbtie_pkg::PH_TAG;
         src = pick_source(seen_in);
         res[n_res] = '{pbtie_pkg::EV_END, 64'd0, src,
                        seen_in[pbtie_pkg::SEEN_NAME] && src != pbtie_pkg::SRC_NONE,
                        fault_in, 1'b0};
         n_res = n_res + 2'd1;
         level_in = pbtie_pkg::LVL_GRAPH;
      end
      if (level_in == pbtie_pkg::LVL_GRAPH && graph_in == '0) begin
         if (phase_in != pbtie_pkg::PH_TAG || cnt_in != '0) fault_in = 1'b1;
         acc_in = '0;
         cnt_in = '0;
         phase_in = pbtie_pkg::PH_TAG;
         level_in = pbtie_pkg::LVL_MODEL;
      end

      if (req_tlast) begin
         incomplete = level_in != pbtie_pkg::LVL_MODEL || phase_in != pbtie_pkg::PH_TAG ||
                      cnt_in != '0;
         if (level_in == pbtie_pkg::LVL_TENSOR) begin
            src = pick_source(seen_in);
            res[n_res] = '{pbtie_pkg::EV_END, 64'd0, src,
                           seen_in[pbtie_pkg::SEEN_NAME] && src != pbtie_pkg::SRC_NONE,
                           1'b1, 1'b0};
            n_res = n_res + 2'd1;
         end else if (incomplete) begin
            res[n_res] = '{pbtie_pkg::EV_END, 64'd0, 3'd0, 1'b0, 1'b1, 1'b0};
            n_res = n_res + 2'd1;
         end
         graph_in  = '0;
         tensor_in = '0;
         field_in  = '0;
         acc_in    = '0;
         cnt_in    = '0;
         phase_in  = pbtie_pkg::PH_TAG;
         level_in  = pbtie_pkg::LVL_MODEL;
         class_in  = pbtie_pkg::CL_SKIP;
         wire_in   = '0;
         seen_in   = '0;
         fault_in  = 1'b0;
      end

      if (n_res != 2'd0) res[n_res - 2'd1].last = 1'b1;
   end

   always_comb begin
      head_in  = head_ff + {1'b0, pop};
      count_in = count_ff - {2'd0, pop} + (accept ? {1'b0, n_res} : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         graph_ff  <= '0;
         tensor_ff <= '0;
         field_ff  <= '0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         phase_ff  <= pbtie_pkg::PH_TAG;
         level_ff  <= pbtie_pkg::LVL_MODEL;
         class_ff  <= pbtie_pkg::CL_SKIP;
         wire_ff   <= '0;
         seen_ff   <= '0;
         fault_ff  <= 1'b0;
         head_ff   <= '0;
         count_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (accept) begin
            graph_ff  <= graph_in;
            tensor_ff <= tensor_in;
            field_ff  <= field_in;
            acc_ff    <= acc_in;
            cnt_ff    <= cnt_in;
            phase_ff  <= phase_in;
            level_ff  <= level_in;
            class_ff  <= class_in;
            wire_ff   <= wire_in;
            seen_ff   <= seen_in;
            fault_ff  <= fault_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (accept && 2'(i) < n_res)
            fifo_ff[2'(head_ff + count_ff[1:0] + 2'(i))] <= res[i];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4) else $error("results queue overfilled");

   a_events_queued: assert property (@(posedge clock) disable iff (reset)
      (accept && n_res != 2'd0) |=> count_ff != 3'd0)
      else $error("events of a transfer were not queued");

   a_tensor_level: assert property (@(posedge clock) disable iff (reset)
      level_ff == pbtie_pkg::LVL_TENSOR |-> tensor_ff != '0)
      else $error("tensor level held with nothing left");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> count_ff <= 3'd1) else $error("ready without room for three events");

endmodule
